### design/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg: bitmap page allocator shared definitions
// Sizes, codes, channel payloads and sequencer states for the allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

	localparam int PAGES       = 4096;
	localparam int WORD_BITS   = 32;
	localparam int MAP_WORDS   = PAGES / WORD_BITS;
	localparam int PAGE_IDX_W  = $clog2(PAGES);
	localparam int COUNT_W     = PAGE_IDX_W + 1;
	localparam int BIT_IDX_W   = $clog2(WORD_BITS);
	localparam int WORD_IDX_W  = $clog2(MAP_WORDS);
	localparam int CHUNK_BITS  = 8;
	localparam int CHUNK_IDX_W = $clog2(WORD_BITS / CHUNK_BITS);
	localparam int CHUNK_OFS_W = $clog2(CHUNK_BITS);
	localparam int POP_W       = $clog2(WORD_BITS + 1);

	typedef enum logic [0:0] {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NO_FREE = 2'd1,
		ST_NO_FIT  = 2'd2,
		ST_RANGE   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SRD,
		S_SCAN,
		S_MRD,
		S_MWR,
		S_DONE
	} state_t;

	typedef struct packed {
		opcode_t                opcode;
		logic [PAGE_IDX_W-1:0]  start_page;
		logic [COUNT_W-1:0]     page_count;
	} req_t;

	typedef struct packed {
		status_t                status;
		logic [PAGE_IDX_W-1:0]  run_start;
		logic [COUNT_W-1:0]     pages_free;
	} rsp_t;

	function automatic logic [POP_W-1:0] popcount(input logic [WORD_BITS-1:0] w);
		logic [POP_W-1:0] n;
		n = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			n = n + POP_W'(w[i]);
		end
		return n;
	endfunction

endpackage

### design/bpa_if.sv
// ----------------------------------------------------------------------------
// bpa_if: allocator channel interfaces
// Valid/ready channels for requests, responses and the page limit register.
// ----------------------------------------------------------------------------
interface bpa_req_if;
	logic          valid;
	logic          ready;
	bpa_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface bpa_rsp_if;
	logic          valid;
	logic          ready;
	bpa_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface bpa_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [bpa_pkg::COUNT_W-1:0]  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### design/bitmap_page_allocator_core.sv
// ----------------------------------------------------------------------------
// bitmap_page_allocator_core: first-fit page allocator
// Used/free bitmap in a word memory, free page counter, word-serial sequencer.
// ----------------------------------------------------------------------------
// channel  dir  payload                                  transfer
// req      in   opcode, start_page, page_count           valid & ready
// rsp      out  status, run_start, pages_free            valid & ready
// cfg      in   page_limit                               valid & ready
//
// one request at a time; req.ready is high only while the sequencer is idle
// rejected requests: from idle straight to the done state, then into the response register
// allocate search: per bitmap word scanned, one read, then four 8-page steps
// range marking or freeing: per word touched, a read, then a write back
// a waiting response does not block the next request from being taken
// reset: every page used via per-word valid flags, no clearing pass
// ----------------------------------------------------------------------------
module bitmap_page_allocator_core (
	input  logic          clk,
	input  logic          arst_n,
	bpa_req_if.sink       req,
	bpa_rsp_if.source     rsp,
	bpa_cfg_if.sink       cfg
);

	localparam int PW = bpa_pkg::PAGE_IDX_W;
	localparam int CW = bpa_pkg::COUNT_W;
	localparam int WB = bpa_pkg::WORD_BITS;
	localparam int BI = bpa_pkg::BIT_IDX_W;
	localparam int WI = bpa_pkg::WORD_IDX_W;

	bpa_pkg::state_t   state_q, state_d;
	bpa_pkg::opcode_t  op_q, op_d;
	bpa_pkg::status_t  status_q, status_d;
	logic [CW-1:0]     cnt_q, cnt_d;
	logic [PW-1:0]     start_q, start_d;
	logic [PW-1:0]     last_q, last_d;
	logic [PW-1:0]     run_at_q, run_at_d;
	logic [WI-1:0]     word_q, word_d;
	logic [bpa_pkg::CHUNK_IDX_W-1:0] chunk_q, chunk_d;
	logic [CW-1:0]     run_q, run_d;
	logic [CW-1:0]     free_q, free_d;
	logic [CW-1:0]     limit_q;
	logic [CW-1:0]     lim;

	logic [WB-1:0]     mem [bpa_pkg::MAP_WORDS];
	logic [bpa_pkg::MAP_WORDS-1:0] valid_q;
	logic [WB-1:0]     rd_data_q;
	logic              rd_vld_q;
	logic              rd_en;
	logic              wr_en;
	logic [WB-1:0]     wr_data;
	logic [WB-1:0]     word_data;

	logic              out_valid_q;
	bpa_pkg::rsp_t     out_q;
	logic              out_load;

	logic              req_fire;

	assign lim       = (limit_q > CW'(bpa_pkg::PAGES)) ? CW'(bpa_pkg::PAGES) : limit_q;
	assign req.ready = (state_q == bpa_pkg::S_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign cfg.ready = 1'b1;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;
	assign word_data = rd_vld_q ? rd_data_q : '1;

	// bitmap word memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[word_q] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[word_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[word_q] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= valid_q[word_q];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bpa_pkg::S_IDLE;
			free_q      <= '0;
			limit_q     <= CW'(bpa_pkg::PAGES);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			free_q  <= free_d;
			if (cfg.valid && cfg.ready) begin
				limit_q <= cfg.data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		op_q     <= op_d;
		status_q <= status_d;
		cnt_q    <= cnt_d;
		start_q  <= start_d;
		last_q   <= last_d;
		run_at_q <= run_at_d;
		word_q   <= word_d;
		chunk_q  <= chunk_d;
		run_q    <= run_d;
		if (out_load) begin
			out_q.status     <= status_q;
			out_q.run_start  <= run_at_q;
			out_q.pages_free <= free_q;
		end
	end

	always_comb begin
		logic [CW:0]         sum;
		logic [CW-1:0]       base;
		logic [CW-1:0]       pg;
		logic [CW-1:0]       run;
		logic [CW-1:0]       fpg;
		logic [CW-1:0]       at;
		logic                found;
		logic [bpa_pkg::CHUNK_BITS-1:0] bits;
		logic [BI-1:0]       lo;
		logic [BI-1:0]       hi;
		logic [WB-1:0]       mask;
		logic [bpa_pkg::POP_W-1:0] pop;

		state_d  = state_q;
		op_d     = op_q;
		status_d = status_q;
		cnt_d    = cnt_q;
		start_d  = start_q;
		last_d   = last_q;
		run_at_d = run_at_q;
		word_d   = word_q;
		chunk_d  = chunk_q;
		run_d    = run_q;
		free_d   = free_q;
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		wr_data  = word_data;
		out_load = 1'b0;

		sum   = (CW+1)'(req.data.start_page) + (CW+1)'(req.data.page_count);
		base  = {1'b0, word_q, chunk_q, {bpa_pkg::CHUNK_OFS_W{1'b0}}};
		pg    = '0;
		run   = run_q;
		found = 1'b0;
		fpg   = '0;
		bits  = word_data[{chunk_q, {bpa_pkg::CHUNK_OFS_W{1'b0}}} +: bpa_pkg::CHUNK_BITS];
		at    = '0;
		lo    = (word_q == start_q[BI +: WI]) ? start_q[BI-1:0] : '0;
		hi    = (word_q == last_q[BI +: WI]) ? last_q[BI-1:0] : BI'(WB - 1);
		mask  = ({WB{1'b1}} << lo) & ({WB{1'b1}} >> (BI'(WB - 1) - hi));
		pop   = '0;

		unique case (state_q)
			bpa_pkg::S_IDLE: begin
				if (req_fire) begin
					op_d     = req.data.opcode;
					cnt_d    = req.data.page_count;
					run_at_d = '0;
					status_d = bpa_pkg::ST_OK;
					run_d    = '0;
					chunk_d  = '0;
					if (req.data.opcode == bpa_pkg::OP_ALLOC) begin
						word_d = '0;
						if (free_q == '0) begin
							status_d = bpa_pkg::ST_NO_FREE;
							state_d  = bpa_pkg::S_DONE;
						end else if (req.data.page_count == '0 ||
								req.data.page_count > lim) begin
							status_d = bpa_pkg::ST_NO_FIT;
							state_d  = bpa_pkg::S_DONE;
						end else begin
							state_d = bpa_pkg::S_SRD;
						end
					end else begin
						start_d = req.data.start_page;
						last_d  = PW'(sum - (CW+1)'(1));
						word_d  = req.data.start_page[BI +: WI];
						if (sum > (CW+1)'(lim)) begin
							status_d = bpa_pkg::ST_RANGE;
							state_d  = bpa_pkg::S_DONE;
						end else if (req.data.page_count == '0) begin
							state_d = bpa_pkg::S_DONE;
						end else begin
							state_d = bpa_pkg::S_MRD;
						end
					end
				end
			end
			bpa_pkg::S_SRD: begin
				rd_en   = 1'b1;
				state_d = bpa_pkg::S_SCAN;
			end
			bpa_pkg::S_SCAN: begin
				for (int i = 0; i < bpa_pkg::CHUNK_BITS; i++) begin
					pg = base + CW'(i);
					if (!found && pg < lim) begin
						if (bits[i]) begin
							run = '0;
						end else begin
							run = run + CW'(1);
							if (run == cnt_q) begin
								found = 1'b1;
								fpg   = pg;
							end
						end
					end
				end
				run_d = run;
				if (found) begin
					at       = fpg + CW'(1) - cnt_q;
					run_at_d = at[PW-1:0];
					start_d  = at[PW-1:0];
					last_d   = fpg[PW-1:0];
					word_d   = at[BI +: WI];
					state_d  = bpa_pkg::S_MRD;
				end else if (base + CW'(bpa_pkg::CHUNK_BITS) >= lim) begin
					status_d = bpa_pkg::ST_NO_FIT;
					state_d  = bpa_pkg::S_DONE;
				end else begin
					chunk_d = chunk_q + 1'b1;
					if (&chunk_q) begin
						word_d  = word_q + 1'b1;
						state_d = bpa_pkg::S_SRD;
					end
				end
			end
			bpa_pkg::S_MRD: begin
				rd_en   = 1'b1;
				state_d = bpa_pkg::S_MWR;
			end
			bpa_pkg::S_MWR: begin
				wr_en = 1'b1;
				if (op_q == bpa_pkg::OP_ALLOC) begin
					wr_data = word_data | mask;
					pop     = bpa_pkg::popcount(mask);
					free_d  = (free_q >= CW'(pop)) ? free_q - CW'(pop) : '0;
				end else begin
					wr_data = word_data & ~mask;
					pop     = bpa_pkg::popcount(word_data & mask);
					free_d  = free_q + CW'(pop);
				end
				if (word_q == last_q[BI +: WI]) begin
					state_d = bpa_pkg::S_DONE;
				end else begin
					word_d  = word_q + 1'b1;
					state_d = bpa_pkg::S_MRD;
				end
			end
			bpa_pkg::S_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = bpa_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bpa_pkg::S_IDLE;
			end
		endcase
	end

endmodule
